FILE: hw/rtl/led_hover_band_renderer_core_macros.svh
// Assertion macros shared by the hover band renderer RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef LED_HOVER_BAND_RENDERER_CORE_MACROS_SVH
`define LED_HOVER_BAND_RENDERER_CORE_MACROS_SVH

`ifndef SYNTH

// Antecedent implies consequent in the same cycle.
`define LHB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Antecedent implies consequent in the next cycle.
`define LHB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define LHB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LHB_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/lhb_pkg.sv
// Shared types, constants and color helpers for the hover band renderer.
// Depends on nothing; used by the divider and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lhb_pkg;

    // Fixed field widths.
    localparam int unsigned COLOR_W = 24;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned DVD_W   = 16;
    localparam int unsigned HALF_W  = 8;
    localparam int unsigned PHASE_W = 4;

    // Idle level of every byte on the strip.
    localparam logic [7:0]         IDLE_BYTE  = 8'h80;
    localparam logic [COLOR_W-1:0] IDLE_PIXEL = 24'h808080;
    localparam logic [7:0]         FULL_BYTE  = 8'hff;

    // Band geometry.
    localparam logic [DVD_W-1:0]   BASE_OFFSET     = 16'd85;
    localparam logic [PHASE_W-1:0] PHASE_LEAD      = 4'd9;
    localparam logic [PHASE_W-1:0] PHASE_MID_FIRST = 4'd10;
    localparam logic [PHASE_W-1:0] PHASE_TRAIL     = 4'd14;

    // Reset value of the pixel count register.
    localparam logic [COUNT_W-1:0] PIXEL_COUNT_RST = 9'd256;

    typedef enum logic {
        ACT_RENDER = 1'b0,
        ACT_READ   = 1'b1
    } action_t;

    typedef enum logic {
        CFG_FILL_COLOR  = 1'b0,
        CFG_PIXEL_COUNT = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD_WAIT,
        ST_CLEAR,
        ST_DIV_Q,
        ST_DIV_B,
        ST_WALK_I,
        ST_WALK_J
    } state_t;

    // Scale one color byte by s/512 and raise it to the idle level.
    function automatic logic [7:0] scale_byte(input logic [7:0] c, input logic [7:0] s);
        logic [15:0] prod;
        prod = 16'(c) * 16'(s);
        return IDLE_BYTE | 8'(prod >> 9);
    endfunction

    // Scaled band pixel in GRB order.
    function automatic logic [COLOR_W-1:0] band_pixel(input logic [COLOR_W-1:0] color,
                                                      input logic [7:0] s);
        return {scale_byte(color[23:16], s), scale_byte(color[15:8], s),
                scale_byte(color[7:0], s)};
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lhb_if.sv
// Valid/ready channel interfaces of the hover band renderer.
// Request, response and configuration channels; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface lhb_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] whole_shift;
    logic [7:0]  frac_shift;
    logic [7:0]  pixel_index;

    modport source (output valid, action, whole_shift, frac_shift, pixel_index,
                    input ready);
    modport sink   (input valid, action, whole_shift, frac_shift, pixel_index,
                    output ready);
endinterface

interface lhb_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] green_byte;
    logic [7:0] red_byte;
    logic [7:0] blue_byte;

    modport source (output valid, green_byte, red_byte, blue_byte, input ready);
    modport sink   (input valid, green_byte, red_byte, blue_byte, output ready);
endinterface

interface lhb_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/led_hover_band_renderer_core.sv
// Hover band renderer for an LED strip. After reset the pixel memory is swept to the idle
// level, one pixel per cycle, and no request beat is taken until the sweep ends
// (configuration writes are taken throughout). A read beat returns one pixel in GRB order
// through the single memory read port; the next request beat can be taken once the block
// is back in idle, in a cycle where its response beat is taken or has already gone; no
// request beat is taken while a response beat waits unaccepted. A render beat keeps the
// block busy while it clears the n pixels in use through the single write port, runs the
// two 16-step remainders that set the band start and the strip base, and then takes n/2
// walk steps, each of which writes two pixels when it falls inside the band. With a count
// of one only the clearing remains. Band pixels at or above the count are never touched.
// Reads of indexes at or above MAX_PIXELS return the idle level. Configuration should be
// written only while the block is idle.
// Depends on lhb_pkg, lhb_if, lhb_ram, lhb_moddiv and the macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "led_hover_band_renderer_core_macros.svh"

module led_hover_band_renderer_core #(
    parameter int unsigned MAX_PIXELS = 256
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lhb_req_if.sink    req,
    lhb_rsp_if.source  rsp,
    lhb_cfg_if.sink    cfg
);

    import lhb_pkg::*;

    localparam int unsigned AW  = $clog2(MAX_PIXELS);
    localparam int unsigned CAP = (MAX_PIXELS < 511) ? MAX_PIXELS : 511;
    localparam logic [COUNT_W-1:0] CAP_N     = COUNT_W'(CAP);
    localparam logic [AW-1:0]      INIT_LAST = AW'(MAX_PIXELS - 1);
    localparam logic [12:0]        MAX_IDX   = 13'(MAX_PIXELS);

    // Configuration registers.
    logic [COLOR_W-1:0] fill_color_reg;
    logic [COUNT_W-1:0] pixel_count_reg;

    // Control state.
    state_t             state_reg, state_next;
    logic [AW-1:0]      init_cnt_reg, init_cnt_next;
    logic [COUNT_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [HALF_W-1:0]  k_reg, k_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // Per-item payload.
    logic [HALF_W-1:0]  m_reg, m_next;
    logic [COUNT_W-1:0] b0_reg, b0_next;
    logic [DVD_W-1:0]   q_reg;
    logic [COUNT_W-1:0] n_reg;
    logic [COLOR_W-1:0] lead_reg;
    logic [COLOR_W-1:0] trail_reg;
    logic               rd_oob_reg;
    logic [COLOR_W-1:0] rsp_data_reg;

    // Datapath nets.
    logic               req_fire;
    logic               is_read;
    logic [COUNT_W-1:0] n_eff;
    logic [HALF_W-1:0]  half;
    logic [HALF_W-1:0]  half_last;
    logic [COUNT_W:0]   sum_i;
    logic [COUNT_W-1:0] idx_i;
    logic [COUNT_W-1:0] idx_j;
    logic [COLOR_W-1:0] mid_px;
    logic [COLOR_W-1:0] band_px;
    logic               walk_last;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [COLOR_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [COLOR_W-1:0] ram_rdata;

    logic               div_start;
    logic [DVD_W-1:0]   div_dividend;
    logic [COUNT_W-1:0] div_divisor;
    logic               div_done;
    logic [COUNT_W-1:0] div_rem;

    // Handshakes.
    assign req.ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;
    assign is_read   = (action_t'(req.action) == ACT_READ);
    assign cfg.ready = 1'b1;

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.green_byte = rsp_data_reg[23:16];
    assign rsp.red_byte   = rsp_data_reg[15:8];
    assign rsp.blue_byte  = rsp_data_reg[7:0];

    // Pixel count in use, limited to the memory size.
    assign n_eff = (pixel_count_reg > CAP_N) ? CAP_N : pixel_count_reg;

    // Band geometry for the current step.
    assign half      = n_reg[COUNT_W-1:1];
    assign half_last = half - 1'b1;
    assign sum_i     = {1'b0, b0_reg} + (COUNT_W + 1)'(m_reg);
    assign idx_i     = (sum_i >= {1'b0, n_reg}) ? COUNT_W'(sum_i - {1'b0, n_reg})
                                                 : sum_i[COUNT_W-1:0];
    assign idx_j     = (b0_reg >= COUNT_W'(m_reg))
                       ? COUNT_W'(b0_reg - COUNT_W'(m_reg))
                       : COUNT_W'(b0_reg + n_reg - COUNT_W'(m_reg));
    assign walk_last = (k_reg == half_last);

    // Band colors: scaled edges and a full-value middle.
    assign mid_px = fill_color_reg | IDLE_PIXEL;
    always_comb
    begin
        priority if (phase_reg == PHASE_LEAD)
        begin
            band_px = lead_reg;
        end
        else if (phase_reg == PHASE_TRAIL)
        begin
            band_px = trail_reg;
        end
        else
        begin
            band_px = mid_px;
        end
    end

    // Remainder unit operands: band start first, then strip base.
    assign div_dividend = (state_reg == ST_CLEAR) ? q_reg : BASE_OFFSET;
    assign div_divisor  = (state_reg == ST_CLEAR) ? {1'b0, half} : n_reg;

    assign ram_raddr = AW'(req.pixel_index);

    // Sequencer: next state, memory writes and counters.
    always_comb
    begin
        state_next     = state_reg;
        init_cnt_next  = init_cnt_reg;
        clr_cnt_next   = clr_cnt_reg;
        k_next         = k_reg;
        phase_next     = phase_reg;
        m_next         = m_reg;
        b0_next        = b0_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        ram_we         = 1'b0;
        ram_waddr      = AW'(clr_cnt_reg);
        ram_wdata      = IDLE_PIXEL;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = init_cnt_reg;
                if (init_cnt_reg == INIT_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    init_cnt_next = init_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (is_read)
                    begin
                        state_next = ST_RD_WAIT;
                    end
                    else if (n_eff != '0)
                    begin
                        state_next   = ST_CLEAR;
                        clr_cnt_next = '0;
                    end
                end
            end
            ST_RD_WAIT:
            begin
                rsp_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (clr_cnt_reg == n_reg - 1'b1)
                begin
                    if (half != '0)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV_Q;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_DIV_Q:
            begin
                if (div_done)
                begin
                    m_next     = div_rem[HALF_W-1:0];
                    div_start  = 1'b1;
                    state_next = ST_DIV_B;
                end
            end
            ST_DIV_B:
            begin
                if (div_done)
                begin
                    b0_next    = div_rem;
                    k_next     = '0;
                    phase_next = '0;
                    state_next = ST_WALK_I;
                end
            end
            ST_WALK_I, ST_WALK_J:
            begin
                if ((state_reg == ST_WALK_I) && (phase_reg >= PHASE_LEAD))
                begin
                    // First write of a band step.
                    ram_we     = 1'b1;
                    ram_waddr  = AW'(idx_i);
                    ram_wdata  = band_px;
                    state_next = ST_WALK_J;
                end
                else
                begin
                    // Mirror write, or a step outside the band: move on.
                    ram_we     = (state_reg == ST_WALK_J);
                    ram_waddr  = AW'(idx_j);
                    ram_wdata  = band_px;
                    if (walk_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_WALK_I;
                        k_next     = k_reg + 1'b1;
                        phase_next = (phase_reg == PHASE_TRAIL) ? '0 : phase_reg + 1'b1;
                        m_next     = (m_reg == half_last) ? '0 : m_reg + 1'b1;
                    end
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_cnt_reg  <= '0;
            clr_cnt_reg   <= '0;
            k_reg         <= '0;
            phase_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            clr_cnt_reg   <= clr_cnt_next;
            k_reg         <= k_next;
            phase_reg     <= phase_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_color_reg  <= '0;
            pixel_count_reg <= PIXEL_COUNT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_FILL_COLOR:  fill_color_reg  <= cfg.data;
                CFG_PIXEL_COUNT: pixel_count_reg <= cfg.data[COUNT_W-1:0];
            endcase
        end
    end

    // Item payload, captured on the accepted beat; walk offsets every cycle; read data in the wait state.
    always_ff @(posedge clk)
    begin
        m_reg  <= m_next;
        b0_reg <= b0_next;
        if (req_fire)
        begin
            q_reg      <= req.whole_shift;
            n_reg      <= n_eff;
            lead_reg   <= band_pixel(fill_color_reg, FULL_BYTE - req.frac_shift);
            trail_reg  <= band_pixel(fill_color_reg, req.frac_shift);
            rd_oob_reg <= (13'(req.pixel_index) >= MAX_IDX);
        end
        if (state_reg == ST_RD_WAIT)
        begin
            rsp_data_reg <= rd_oob_reg ? IDLE_PIXEL : ram_rdata;
        end
    end

    lhb_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MAX_PIXELS)
    ) u_pixel_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lhb_moddiv u_moddiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .rem      (div_rem)
    );

    // A read beat is followed by the memory wait, which always yields a result beat.
    `LHB_ASSERT_NXT(a_read_to_wait, clk, rst_n, req_fire && is_read, state_reg == ST_RD_WAIT)
    `LHB_ASSERT_NXT(a_wait_to_rsp, clk, rst_n, state_reg == ST_RD_WAIT, rsp.valid)
    // The pixel memory is never written while reads may be in flight.
    `LHB_ASSERT_IMP(a_no_write_idle, clk, rst_n, ram_we,
                    (state_reg != ST_IDLE) && (state_reg != ST_RD_WAIT))
    // Band writes stay inside the pixels in use.
    `LHB_ASSERT_IMP(a_walk_bounds, clk, rst_n,
                    (state_reg == ST_WALK_I) || (state_reg == ST_WALK_J),
                    (m_reg < half) && (idx_i < n_reg) && (idx_j < n_reg))

endmodule

`default_nettype wire

FILE: hw/rtl/lhb_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lhb_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lhb_moddiv.sv
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on lhb_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module lhb_moddiv (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [lhb_pkg::DVD_W-1:0]   dividend,
    input  wire logic [lhb_pkg::COUNT_W-1:0] divisor,
    output logic                             done,
    output logic      [lhb_pkg::COUNT_W-1:0] rem
);

    import lhb_pkg::*;

    localparam int unsigned CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [COUNT_W-1:0] dsr_reg, dsr_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W:0]   trial;

    // One restoring step per cycle; done pulses after the last step.
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CNT_W'(DVD_W);
            dvd_next = dividend;
            dsr_next = divisor;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            dvd_next  = dvd_reg << 1;
            done_next = (cnt_reg == CNT_W'(1));
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = COUNT_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[COUNT_W-1:0];
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Operands and partial remainder.
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire
